@@ rtl/cpc_pkg.sv @@
`default_nettype none

package cpc_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned IDX_W       = $clog2(BLOCK_WORDS);
  localparam int unsigned DR_W        = 4;
  localparam logic [DR_W-1:0] DR_RESET = 4'd10;
  localparam int unsigned STEP_W      = 5;

  // quarter-round rotate amounts
  localparam int unsigned ROT_A1 = 16;
  localparam int unsigned ROT_A2 = 12;
  localparam int unsigned ROT_B1 = 8;
  localparam int unsigned ROT_B2 = 7;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_QR_A,
    OP_QR_B,
    OP_EMIT
  } op_e;

  // row rotation applied after a quarter-round half
  typedef enum logic [1:0] {
    PERM_NONE,
    PERM_ROT,
    PERM_ROT_DIAG,
    PERM_ROT_UNDIAG
  } perm_e;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_WORDS_LEFT,
    COND_ROUNDS_ZERO,
    COND_ROUNDS_LEFT
  } cond_e;

  typedef struct packed {
    op_e               op;
    perm_e             perm;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  localparam logic [STEP_W-1:0] STEP_LOAD  = 5'd0;
  localparam logic [STEP_W-1:0] STEP_ROUND = 5'd2;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 5'd18;

  // Microcode: load, optional skip, one double round (16 half steps), emit.
  function automatic ctrl_t rom_word(input logic [STEP_W-1:0] step);
    ctrl_t cw;
    cw = '{OP_NOP, PERM_NONE, COND_ALWAYS, STEP_LOAD};
    unique case (step)
      5'd0:  cw = '{OP_LOAD, PERM_NONE,       COND_WORDS_LEFT,  STEP_LOAD};
      5'd1:  cw = '{OP_NOP,  PERM_NONE,       COND_ROUNDS_ZERO, STEP_EMIT};
      // column quarter rounds
      5'd2:  cw = '{OP_QR_A, PERM_NONE,       COND_NONE,        STEP_LOAD};
      5'd3:  cw = '{OP_QR_B, PERM_ROT,        COND_NONE,        STEP_LOAD};
      5'd4:  cw = '{OP_QR_A, PERM_NONE,       COND_NONE,        STEP_LOAD};
      5'd5:  cw = '{OP_QR_B, PERM_ROT,        COND_NONE,        STEP_LOAD};
      5'd6:  cw = '{OP_QR_A, PERM_NONE,       COND_NONE,        STEP_LOAD};
      5'd7:  cw = '{OP_QR_B, PERM_ROT,        COND_NONE,        STEP_LOAD};
      5'd8:  cw = '{OP_QR_A, PERM_NONE,       COND_NONE,        STEP_LOAD};
      5'd9:  cw = '{OP_QR_B, PERM_ROT_DIAG,   COND_NONE,        STEP_LOAD};
      // diagonal quarter rounds
      5'd10: cw = '{OP_QR_A, PERM_NONE,       COND_NONE,        STEP_LOAD};
      5'd11: cw = '{OP_QR_B, PERM_ROT,        COND_NONE,        STEP_LOAD};
      5'd12: cw = '{OP_QR_A, PERM_NONE,       COND_NONE,        STEP_LOAD};
      5'd13: cw = '{OP_QR_B, PERM_ROT,        COND_NONE,        STEP_LOAD};
      5'd14: cw = '{OP_QR_A, PERM_NONE,       COND_NONE,        STEP_LOAD};
      5'd15: cw = '{OP_QR_B, PERM_ROT,        COND_NONE,        STEP_LOAD};
      5'd16: cw = '{OP_QR_A, PERM_NONE,       COND_NONE,        STEP_LOAD};
      5'd17: cw = '{OP_QR_B, PERM_ROT_UNDIAG, COND_ROUNDS_LEFT, STEP_ROUND};
      5'd18: cw = '{OP_EMIT, PERM_NONE,       COND_WORDS_LEFT,  STEP_EMIT};
      5'd19: cw = '{OP_NOP,  PERM_NONE,       COND_ALWAYS,      STEP_LOAD};
      default: ;
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

@@ rtl/chacha_permutation_core.sv @@
`default_nettype none

// Channel | Dir | Handshake               | Payload
// --------+-----+-------------------------+----------------------------------------
// in      | in  | in_valid_i / in_ready_o | in_word_i (32b), words 0..15 in order
// out     | out | out_valid_o/ out_ready_i| out_word_o, out_index_o, out_last_o
// cfg     | in  | cfg_valid_i/ cfg_ready_o| cfg_double_rounds_i (4b), reset 10
//
// Per block of 16 words: load, a check that may skip the rounds, R double rounds
// (R = double_rounds), emit, then an idle step. Each double round is 16 microcode
// steps: one half quarter round per cycle through the shared quarter-round unit.
// Reset (async, active low) restarts the program at the load step with R = 10.
// Input stalls hold the load step; output stalls hold the emit step. The output
// register lets the next block's loading start while word 15 still waits.
module chacha_permutation_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,

  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [cpc_pkg::WORD_W-1:0]   in_word_i,

  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [cpc_pkg::WORD_W-1:0]   out_word_o,
  output logic      [cpc_pkg::IDX_W-1:0]    out_index_o,
  output logic                              out_last_o,

  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [cpc_pkg::DR_W-1:0]     cfg_double_rounds_i
);

  localparam int unsigned W  = cpc_pkg::WORD_W;
  localparam int unsigned NW = cpc_pkg::BLOCK_WORDS;
  localparam int unsigned IW = cpc_pkg::IDX_W;
  localparam int unsigned SW = cpc_pkg::STEP_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(NW - 1);

  // sequencer state
  logic [SW-1:0]             step_q, step_d;
  logic [IW-1:0]             wcnt_q, wcnt_d;
  logic [cpc_pkg::DR_W-1:0]  rnd_q, rnd_d;
  logic [cpc_pkg::DR_W-1:0]  dr_q;
  cpc_pkg::ctrl_t            ctrl;

  // state words and output register
  logic [W-1:0]  w_q [NW];
  logic [W-1:0]  w_d [NW];
  logic [W-1:0]  t   [NW];
  logic [W-1:0]  w_perm [NW];
  logic          out_valid_q, out_valid_d;
  logic [W-1:0]  out_word_q;
  logic [IW-1:0] out_index_q;
  logic          out_last_q;

  logic          in_fire, emit_fire, advance, cond_hit;
  logic [W-1:0]  qa, qb, qc, qd;
  logic [1:0]    sh [4];

  assign ctrl        = cpc_pkg::rom_word(step_q);
  assign in_ready_o  = (ctrl.op == cpc_pkg::OP_LOAD);
  assign in_fire     = in_valid_i && in_ready_o;
  assign emit_fire   = (ctrl.op == cpc_pkg::OP_EMIT) && (!out_valid_q || out_ready_i);
  assign cfg_ready_o = 1'b1;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_index_o = out_index_q;
  assign out_last_o  = out_last_q;

  // column 0 (words 0, 4, 8, 12) always feeds the quarter-round unit
  cpc_qr_half u_qr (
    .a_i      (w_q[0]),
    .b_i      (w_q[4]),
    .c_i      (w_q[8]),
    .d_i      (w_q[12]),
    .second_i (ctrl.op == cpc_pkg::OP_QR_B),
    .a_o      (qa),
    .b_o      (qb),
    .c_o      (qc),
    .d_o      (qd)
  );

  // Row rotate amounts. Plain rotation brings the next column to position 0;
  // the diag variant also skews rows so diagonals line up as columns, the
  // undiag variant removes the skew.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sh[r] = 2'd0;
    end
    unique case (ctrl.perm)
      cpc_pkg::PERM_NONE: ;
      cpc_pkg::PERM_ROT: begin
        for (int r = 0; r < 4; r++) begin
          sh[r] = 2'd1;
        end
      end
      cpc_pkg::PERM_ROT_DIAG: begin
        sh[0] = 2'd1; sh[1] = 2'd2; sh[2] = 2'd3; sh[3] = 2'd0;
      end
      cpc_pkg::PERM_ROT_UNDIAG: begin
        sh[0] = 2'd1; sh[1] = 2'd0; sh[2] = 2'd3; sh[3] = 2'd2;
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      t[i] = w_q[i];
    end
    t[0]  = qa;
    t[4]  = qb;
    t[8]  = qc;
    t[12] = qd;
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        w_perm[4*r+j] = t[{2'(r), 2'(2'(j) + sh[r])}];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      w_d[i] = w_q[i];
    end
    unique case (ctrl.op)
      cpc_pkg::OP_LOAD, cpc_pkg::OP_EMIT: begin
        // shift chain: loads enter at the top, emits leave from word 0
        if (in_fire || emit_fire) begin
          for (int i = 0; i < NW - 1; i++) begin
            w_d[i] = w_q[i+1];
          end
          w_d[NW-1] = in_word_i;
        end
      end
      cpc_pkg::OP_QR_A, cpc_pkg::OP_QR_B: begin
        for (int i = 0; i < NW; i++) begin
          w_d[i] = w_perm[i];
        end
      end
      default: ;
    endcase
  end

  // step counter, branch and loop counters
  always_comb begin
    unique case (ctrl.op)
      cpc_pkg::OP_LOAD: advance = in_fire;
      cpc_pkg::OP_EMIT: advance = emit_fire;
      default:          advance = 1'b1;
    endcase

    unique case (ctrl.cond)
      cpc_pkg::COND_NONE:        cond_hit = 1'b0;
      cpc_pkg::COND_ALWAYS:      cond_hit = 1'b1;
      cpc_pkg::COND_WORDS_LEFT:  cond_hit = (wcnt_q != LAST_IDX);
      cpc_pkg::COND_ROUNDS_ZERO: cond_hit = (rnd_q == '0);
      cpc_pkg::COND_ROUNDS_LEFT: cond_hit = (rnd_q != cpc_pkg::DR_W'(1));
      default:                   cond_hit = 1'b0;
    endcase

    step_d = step_q;
    if (advance) begin
      step_d = cond_hit ? ctrl.target : step_q + SW'(1);
    end

    wcnt_d = wcnt_q;
    if (in_fire || emit_fire) begin
      wcnt_d = wcnt_q + IW'(1);
    end

    rnd_d = rnd_q;
    if (in_fire && (wcnt_q == LAST_IDX)) begin
      rnd_d = dr_q;
    end else if (ctrl.cond == cpc_pkg::COND_ROUNDS_LEFT) begin
      rnd_d = rnd_q - cpc_pkg::DR_W'(1);
    end

    out_valid_d = out_valid_q;
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= cpc_pkg::STEP_LOAD;
      wcnt_q      <= '0;
      rnd_q       <= '0;
      dr_q        <= cpc_pkg::DR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      wcnt_q      <= wcnt_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        dr_q <= cfg_double_rounds_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NW; i++) begin
      w_q[i] <= w_d[i];
    end
    if (emit_fire) begin
      out_word_q  <= w_q[0];
      out_index_q <= wcnt_q;
      out_last_q  <= (wcnt_q == LAST_IDX);
    end
  end

  // the round loop never runs with an exhausted round count
  a_rounds_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ctrl.op == cpc_pkg::OP_QR_A) || (ctrl.op == cpc_pkg::OP_QR_B)) |-> (rnd_q != '0))
    else $error("quarter-round step with zero rounds left");

  // the sixteenth word of a block leaves the load step
  a_load_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (wcnt_q == LAST_IDX)) |=> (step_q == cpc_pkg::STEP_LOAD + SW'(1)))
    else $error("sequencer did not leave load after last word");

  // word count is back at zero whenever loading resumes
  a_load_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(in_ready_o)) |-> (wcnt_q == '0))
    else $error("load started with nonzero word count");

endmodule

`default_nettype wire

@@ rtl/cpc_qr_half.sv @@
`default_nettype none

// One half of a ChaCha quarter round: two add/xor/rotate pairs.
module cpc_qr_half (
  input  wire logic [cpc_pkg::WORD_W-1:0] a_i,
  input  wire logic [cpc_pkg::WORD_W-1:0] b_i,
  input  wire logic [cpc_pkg::WORD_W-1:0] c_i,
  input  wire logic [cpc_pkg::WORD_W-1:0] d_i,
  input  wire logic                       second_i,
  output logic      [cpc_pkg::WORD_W-1:0] a_o,
  output logic      [cpc_pkg::WORD_W-1:0] b_o,
  output logic      [cpc_pkg::WORD_W-1:0] c_o,
  output logic      [cpc_pkg::WORD_W-1:0] d_o
);

  localparam int unsigned W = cpc_pkg::WORD_W;

  logic [W-1:0] dx, bx;

  always_comb begin
    a_o = a_i + b_i;
    dx  = d_i ^ a_o;
    d_o = second_i ? {dx[W-1-cpc_pkg::ROT_B1:0], dx[W-1:W-cpc_pkg::ROT_B1]}
                   : {dx[W-1-cpc_pkg::ROT_A1:0], dx[W-1:W-cpc_pkg::ROT_A1]};
    c_o = c_i + d_o;
    bx  = b_i ^ c_o;
    b_o = second_i ? {bx[W-1-cpc_pkg::ROT_B2:0], bx[W-1:W-cpc_pkg::ROT_B2]}
                   : {bx[W-1-cpc_pkg::ROT_A2:0], bx[W-1:W-cpc_pkg::ROT_A2]};
  end

endmodule

`default_nettype wire
